// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

// ----- rtl/core/gwa_pkg.sv -----
// ----------------------------------------------------------------------------
// gwa_pkg
// Types and constants of the gated window averager.
// ----------------------------------------------------------------------------
`default_nettype none
package gwa_pkg;
   localparam int WINDOW_MAX_DEF = 16;
   localparam int TIME_W         = 32;
   localparam int TEMP_W         = 15;
   localparam int PRES_W         = 17;
   localparam int HUMI_W         = 17;
   localparam int WL_W           = 5;
   localparam int MIN_W          = 16;
   localparam int CSR_W          = 16;
   localparam int CSR_IDX_W      = 1;
   localparam int TEMP_INVALID   = -5000;
   localparam int TEMP_LIMIT     = -5000;
   localparam int WL_RESET       = 16;
   localparam int MIN_RESET      = 200;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_INTERVAL  = 1'd1;

   typedef struct packed {
      logic clear;
      logic commit;
      logic start;
   } lane_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/core/gwa_ifs.sv -----
// ----------------------------------------------------------------------------
// gwa channel interfaces
// Request and response channels, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface gwa_req_if;
   logic                                valid;
   logic                                ready;
   logic [gwa_pkg::TIME_W-1:0]          now_ms;
   logic signed [gwa_pkg::TEMP_W-1:0]   sample_temperature;
   logic [gwa_pkg::PRES_W-1:0]          sample_pressure;
   logic [gwa_pkg::HUMI_W-1:0]          sample_humidity;
   modport source (output valid, now_ms, sample_temperature, sample_pressure,
                   sample_humidity, input ready);
   modport sink (input valid, now_ms, sample_temperature, sample_pressure,
                 sample_humidity, output ready);
endinterface

interface gwa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                stored;
   logic signed [gwa_pkg::TEMP_W-1:0]   oldest_temperature;
   logic signed [gwa_pkg::TEMP_W-1:0]   avg_temperature;
   logic [gwa_pkg::PRES_W-1:0]          avg_pressure;
   logic [gwa_pkg::HUMI_W-1:0]          avg_humidity;
   logic                                temperature_ok;
   logic                                pressure_ok;
   logic                                humidity_ok;
   modport source (output valid, stored, oldest_temperature, avg_temperature,
                   avg_pressure, avg_humidity, temperature_ok, pressure_ok,
                   humidity_ok, input ready);
   modport sink (input valid, stored, oldest_temperature, avg_temperature,
                 avg_pressure, avg_humidity, temperature_ok, pressure_ok,
                 humidity_ok, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gwa_ram.sv -----
// ----------------------------------------------------------------------------
// gwa_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/core/gwa_div.sv -----
// ----------------------------------------------------------------------------
// gwa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gwa_div #(
   parameter int SUM_W = 21,
   parameter int CNT_W = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic      [SUM_W-1:0] quotient,
   output logic                  done
);
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_sub;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W);
         done_in = 1'b0;
      end else if (step_ff != '0) begin
         rem_in  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         step_in = step_ff - 1'b1;
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

// ----- rtl/core/gwa_lane.sv -----
// ----------------------------------------------------------------------------
// gwa_lane
// One channel: ring store, running sum and count of valid entries, divider.
// ----------------------------------------------------------------------------
`default_nettype none
module gwa_lane #(
   parameter int DATA_W     = 17,
   parameter bit IS_SIGNED  = 1'b0,
   parameter int RESET_VAL  = 0,
   parameter int LIMIT      = 0,
   parameter int WINDOW_MAX = gwa_pkg::WINDOW_MAX_DEF,
   parameter int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gwa_pkg::lane_ctl_type ctl,
   input  wire logic [SLOT_W-1:0]    slot,
   input  wire logic [DATA_W-1:0]    sample,
   output logic      [DATA_W-1:0]    head,
   output logic      [DATA_W-1:0]    avg,
   output logic                      ok,
   output logic                      done
);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = DATA_W + $clog2(WINDOW_MAX) + 1;
   localparam logic [DATA_W-1:0]        RST_V = DATA_W'(RESET_VAL);
   localparam logic signed [DATA_W:0]   LIM_V = (DATA_W+1)'(LIMIT);

   logic [WINDOW_MAX-1:0] valid_ff, valid_in;
   logic                  rd_valid_ff;
   logic [DATA_W-1:0]     ram_q;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      old_ext, new_ext, mag, quo, quo_s;
   logic                  old_ok, new_ok, neg;

   function automatic logic entry_ok(input logic [DATA_W-1:0] x);
      logic signed [DATA_W:0] e;
      e = {(IS_SIGNED ? x[DATA_W-1] : 1'b0), x};
      return e > LIM_V;
   endfunction

   function automatic logic [SUM_W-1:0] extend(input logic [DATA_W-1:0] x);
      logic s;
      s = IS_SIGNED ? x[DATA_W-1] : 1'b0;
      return {{(SUM_W-DATA_W){s}}, x};
   endfunction

   gwa_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW_MAX), .ADDR_W(SLOT_W)) u_ring (
      .clock   (clock),
      .wr_en   (ctl.commit),
      .wr_addr (slot),
      .wr_data (sample),
      .rd_addr (slot),
      .rd_data (ram_q)
   );

   assign head = rd_valid_ff ? ram_q : RST_V;

   always_comb begin
      old_ok  = entry_ok(head);
      new_ok  = entry_ok(sample);
      old_ext = old_ok ? extend(head) : '0;
      new_ext = new_ok ? extend(sample) : '0;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         sum_in   = '0;
         cnt_in   = '0;
         valid_in = '0;
      end else if (ctl.commit) begin
         sum_in = sum_ff - old_ext + new_ext;
         cnt_in = cnt_ff - CNT_W'(old_ok) + CNT_W'(new_ok);
         valid_in[slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[slot];
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
      end
   end

   assign neg = IS_SIGNED && sum_ff[SUM_W-1];
   assign mag = neg ? (~sum_ff + 1'b1) : sum_ff;

   gwa_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.start),
      .dividend (mag),
      .divisor  (cnt_ff),
      .quotient (quo),
      .done     (done)
   );

   assign quo_s = neg ? (~quo + 1'b1) : quo;
   assign ok    = cnt_ff != '0;
   assign avg   = ok ? quo_s[DATA_W-1:0] : '0;
endmodule
`default_nettype wire

// ----- rtl/core/gated_window_average_3ch.sv -----
// ----------------------------------------------------------------------------
// gated_window_average_3ch
// Time-gated windowed averager for temperature, pressure and humidity.
// ----------------------------------------------------------------------------
// One request beat yields one response beat. A beat is stored when more than
// min_interval_ms has passed since the last stored one; each channel lane
// keeps its own ring, running sum and valid count, and divides bit-serially.
// Each item passes through the LOOKUP, PEEK, DIVIDE and DELIVER states; the
// DIVIDE state lasts until the restoring divider of the widest lane is done,
// and the three lanes divide in parallel. The response is registered on
// leaving DELIVER, and a stalled response holds the next one.
// A new request is taken once the previous response is loaded.
// Rings are empty after reset and after every window_length write.
`default_nettype none
module gated_window_average_3ch #(
   parameter int WINDOW_MAX = gwa_pkg::WINDOW_MAX_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   gwa_req_if.sink                            req_chan,
   gwa_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [gwa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gwa_pkg::CSR_W-1:0]     csr_data
);
   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WL_START = (gwa_pkg::WL_RESET > WINDOW_MAX) ? WINDOW_MAX :
                             gwa_pkg::WL_RESET;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOOKUP  = 3'd1;
   localparam logic [2:0] ST_PEEK    = 3'd2;
   localparam logic [2:0] ST_DIVIDE  = 3'd3;
   localparam logic [2:0] ST_DELIVER = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [gwa_pkg::WL_W-1:0]        wl_ff, wl_in, wl_wr;
   logic [gwa_pkg::MIN_W-1:0]       min_ff, min_in;
   logic [SLOT_W-1:0]               slot_ff, slot_in;
   logic [SLOT_W:0]                 slot_inc;
   logic [gwa_pkg::TIME_W-1:0]      last_ff, last_in, now_ff, now_in;
   logic                            gate_ff, gate_in;
   logic [gwa_pkg::TEMP_W-1:0]      temp_ff, temp_in;
   logic [gwa_pkg::PRES_W-1:0]      pres_ff, pres_in;
   logic [gwa_pkg::HUMI_W-1:0]      humi_ff, humi_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            stored_ff;
   logic [gwa_pkg::TEMP_W-1:0]      oldest_ff, tavg_ff;
   logic [gwa_pkg::PRES_W-1:0]      pavg_ff;
   logic [gwa_pkg::HUMI_W-1:0]      havg_ff;
   logic                            tok_ff, pok_ff, hok_ff;
   logic                            accept, load, wl_write, all_done;
   gwa_pkg::lane_ctl_type           ctl;
   logic [gwa_pkg::TEMP_W-1:0]      t_head, t_avg;
   logic [gwa_pkg::PRES_W-1:0]      p_head, p_avg;
   logic [gwa_pkg::HUMI_W-1:0]      h_head, h_avg;
   logic                            t_ok, p_ok, h_ok, t_done, p_done, h_done;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && (state_ff == ST_IDLE);
   assign all_done = t_done && p_done && h_done;
   assign load     = (state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp_chan.ready);
   assign wl_write = csr_wr_en && (csr_index == gwa_pkg::REG_WINDOW_LENGTH);

   assign ctl.clear  = wl_write;
   assign ctl.commit = (state_ff == ST_LOOKUP) && gate_ff;
   assign ctl.start  = (state_ff == ST_PEEK);

   always_comb begin
      if (csr_data[gwa_pkg::WL_W-1:0] == '0) begin
         wl_wr = gwa_pkg::WL_W'(1);
      end else if (int'(csr_data[gwa_pkg::WL_W-1:0]) > WINDOW_MAX) begin
         wl_wr = gwa_pkg::WL_W'(WINDOW_MAX);
      end else begin
         wl_wr = csr_data[gwa_pkg::WL_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      wl_in    = wl_ff;
      min_in   = min_ff;
      slot_in  = slot_ff;
      last_in  = last_ff;
      now_in   = now_ff;
      gate_in  = gate_ff;
      temp_in  = temp_ff;
      pres_in  = pres_ff;
      humi_in  = humi_ff;
      slot_inc = {1'b0, slot_ff} + 1'b1;
      if (wl_write) begin
         wl_in   = wl_wr;
         slot_in = '0;
      end
      if (csr_wr_en && (csr_index == gwa_pkg::REG_MIN_INTERVAL)) begin
         min_in = csr_data[gwa_pkg::MIN_W-1:0];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in   = req_chan.now_ms;
               gate_in  = (req_chan.now_ms - last_ff) >
                          {{(gwa_pkg::TIME_W-gwa_pkg::MIN_W){1'b0}}, min_ff};
               temp_in  = req_chan.sample_temperature;
               pres_in  = req_chan.sample_pressure;
               humi_in  = req_chan.sample_humidity;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (gate_ff) begin
               last_in = now_ff;
               slot_in = (int'(slot_inc) >= int'(wl_ff)) ? '0 : slot_inc[SLOT_W-1:0];
            end
            state_in = ST_PEEK;
         end
         ST_PEEK: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (all_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= gwa_pkg::WL_W'(WL_START);
         min_ff       <= gwa_pkg::MIN_W'(gwa_pkg::MIN_RESET);
         slot_ff      <= '0;
         last_ff      <= '0;
         gate_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         min_ff       <= min_in;
         slot_ff      <= slot_in;
         last_ff      <= last_in;
         gate_ff      <= gate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff  <= now_in;
      temp_ff <= temp_in;
      pres_ff <= pres_in;
      humi_ff <= humi_in;
      if (load) begin
         stored_ff <= gate_ff;
         oldest_ff <= t_head;
         tavg_ff   <= t_avg;
         pavg_ff   <= p_avg;
         havg_ff   <= h_avg;
         tok_ff    <= t_ok;
         pok_ff    <= p_ok;
         hok_ff    <= h_ok;
      end
   end

   gwa_lane #(
      .DATA_W(gwa_pkg::TEMP_W), .IS_SIGNED(1'b1), .RESET_VAL(gwa_pkg::TEMP_INVALID),
      .LIMIT(gwa_pkg::TEMP_LIMIT), .WINDOW_MAX(WINDOW_MAX), .SLOT_W(SLOT_W)
   ) u_temp (
      .clock(clock), .reset(reset), .ctl(ctl), .slot(slot_ff), .sample(temp_ff),
      .head(t_head), .avg(t_avg), .ok(t_ok), .done(t_done)
   );

   gwa_lane #(
      .DATA_W(gwa_pkg::PRES_W), .IS_SIGNED(1'b0), .RESET_VAL(0),
      .LIMIT(0), .WINDOW_MAX(WINDOW_MAX), .SLOT_W(SLOT_W)
   ) u_pres (
      .clock(clock), .reset(reset), .ctl(ctl), .slot(slot_ff), .sample(pres_ff),
      .head(p_head), .avg(p_avg), .ok(p_ok), .done(p_done)
   );

   gwa_lane #(
      .DATA_W(gwa_pkg::HUMI_W), .IS_SIGNED(1'b0), .RESET_VAL(0),
      .LIMIT(0), .WINDOW_MAX(WINDOW_MAX), .SLOT_W(SLOT_W)
   ) u_humi (
      .clock(clock), .reset(reset), .ctl(ctl), .slot(slot_ff), .sample(humi_ff),
      .head(h_head), .avg(h_avg), .ok(h_ok), .done(h_done)
   );

   // heads of pressure and humidity rings only feed their own lane updates
   logic unused_heads;
   assign unused_heads = ^{p_head, h_head};

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.stored             = stored_ff;
   assign rsp_chan.oldest_temperature = oldest_ff;
   assign rsp_chan.avg_temperature    = tavg_ff;
   assign rsp_chan.avg_pressure       = pavg_ff;
   assign rsp_chan.avg_humidity       = havg_ff;
   assign rsp_chan.temperature_ok     = tok_ff;
   assign rsp_chan.pressure_ok        = pok_ff;
   assign rsp_chan.humidity_ok        = hok_ff;

   `include "assert_macros.svh"

   `ASSERT_PROP(a_slot_in_window, clock, reset, int'(slot_ff) < int'(wl_ff))
   `ASSERT_PROP(a_accept_to_lookup, clock, reset, accept |=> state_ff == ST_LOOKUP)
   `ASSERT_PROP(a_rsp_from_deliver, clock, reset,
                $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DELIVER)
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the gated three-channel window averager.
// Requests carry one reading per channel and a timestamp. An in-bench model
// tracks the time gate, the rings, the running sums and the counts, and
// predicts every response. Each response beat is checked field by field
// against the oldest prediction. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   typedef struct packed {
      logic [gwa_pkg::TIME_W-1:0]        now_ms;
      logic signed [gwa_pkg::TEMP_W-1:0] temp;
      logic [gwa_pkg::PRES_W-1:0]        pres;
      logic [gwa_pkg::HUMI_W-1:0]        humi;
   } reading_type;

   typedef struct packed {
      logic                              stored;
      logic signed [gwa_pkg::TEMP_W-1:0] oldest_temp;
      logic signed [gwa_pkg::TEMP_W-1:0] avg_temp;
      logic [gwa_pkg::PRES_W-1:0]        avg_pres;
      logic [gwa_pkg::HUMI_W-1:0]        avg_humi;
      logic                              temp_ok;
      logic                              pres_ok;
      logic                              humi_ok;
   } average_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [gwa_pkg::CSR_IDX_W-1:0] csr_index = gwa_pkg::REG_WINDOW_LENGTH;
   logic [gwa_pkg::CSR_W-1:0] csr_data = '0;

   gwa_req_if req_bus ();
   gwa_rsp_if rsp_bus ();

   gated_window_average_3ch u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   reading_type readings_pending[$];
   average_type averages_expected[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   // window state
   int window_len;
   int min_gap_ms;
   int temp_ring[gwa_pkg::WINDOW_MAX_DEF];
   int pres_ring[gwa_pkg::WINDOW_MAX_DEF];
   int humi_ring[gwa_pkg::WINDOW_MAX_DEF];
   int next_slot;
   logic [gwa_pkg::TIME_W-1:0] last_store_ms;
   int temp_sum, pres_sum, humi_sum;
   int temp_cnt, pres_cnt, humi_cnt;

   task automatic clear_window();
      for (int i = 0; i < gwa_pkg::WINDOW_MAX_DEF; i++) begin
         temp_ring[i] = gwa_pkg::TEMP_INVALID;
         pres_ring[i] = 0;
         humi_ring[i] = 0;
      end
      next_slot = 0;
      temp_sum = 0; pres_sum = 0; humi_sum = 0;
      temp_cnt = 0; pres_cnt = 0; humi_cnt = 0;
   endtask

   task automatic set_window_len(input logic [gwa_pkg::CSR_W-1:0] v);
      int n;
      n = v[gwa_pkg::WL_W-1:0];
      if (n < 1) n = 1;
      if (n > gwa_pkg::WINDOW_MAX_DEF) n = gwa_pkg::WINDOW_MAX_DEF;
      window_len = n;
      clear_window();
   endtask

   task automatic average_reading(input reading_type rd, output average_type av);
      logic [gwa_pkg::TIME_W-1:0] gap;
      int t;
      gap = rd.now_ms - last_store_ms;
      t = rd.temp;
      av = '0;
      if (gap > gwa_pkg::TIME_W'(min_gap_ms)) begin
         av.stored = 1'b1;
         last_store_ms = rd.now_ms;
         if (temp_ring[next_slot] > gwa_pkg::TEMP_LIMIT) begin
            temp_sum -= temp_ring[next_slot]; temp_cnt--;
         end
         if (pres_ring[next_slot] > 0) begin
            pres_sum -= pres_ring[next_slot]; pres_cnt--;
         end
         if (humi_ring[next_slot] > 0) begin
            humi_sum -= humi_ring[next_slot]; humi_cnt--;
         end
         temp_ring[next_slot] = t;
         pres_ring[next_slot] = rd.pres;
         humi_ring[next_slot] = rd.humi;
         if (t > gwa_pkg::TEMP_LIMIT) begin
            temp_sum += t; temp_cnt++;
         end
         if (rd.pres > 0) begin
            pres_sum += rd.pres; pres_cnt++;
         end
         if (rd.humi > 0) begin
            humi_sum += rd.humi; humi_cnt++;
         end
         next_slot++;
         if (next_slot >= window_len) next_slot = 0;
      end
      av.oldest_temp = gwa_pkg::TEMP_W'(temp_ring[next_slot]);
      av.temp_ok = temp_cnt != 0;
      av.pres_ok = pres_cnt != 0;
      av.humi_ok = humi_cnt != 0;
      av.avg_temp = av.temp_ok ? gwa_pkg::TEMP_W'(temp_sum / temp_cnt) : '0;
      av.avg_pres = av.pres_ok ? gwa_pkg::PRES_W'(pres_sum / pres_cnt) : '0;
      av.avg_humi = av.humi_ok ? gwa_pkg::HUMI_W'(humi_sum / humi_cnt) : '0;
   endtask

   // request driver
   always @(posedge clock) begin
      reading_type rd;
      average_type av;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            rd.now_ms = req_bus.now_ms;
            rd.temp   = req_bus.sample_temperature;
            rd.pres   = req_bus.sample_pressure;
            rd.humi   = req_bus.sample_humidity;
            average_reading(rd, av);
            averages_expected.push_back(av);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (readings_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               rd = readings_pending.pop_front();
               req_bus.now_ms             <= rd.now_ms;
               req_bus.sample_temperature <= rd.temp;
               req_bus.sample_pressure    <= rd.pres;
               req_bus.sample_humidity    <= rd.humi;
               req_bus.valid              <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      average_type got, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= $urandom_range(99) >= recv_idle_pct;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.stored      = rsp_bus.stored;
            got.oldest_temp = rsp_bus.oldest_temperature;
            got.avg_temp    = rsp_bus.avg_temperature;
            got.avg_pres    = rsp_bus.avg_pressure;
            got.avg_humi    = rsp_bus.avg_humidity;
            got.temp_ok     = rsp_bus.temperature_ok;
            got.pres_ok     = rsp_bus.pressure_ok;
            got.humi_ok     = rsp_bus.humidity_ok;
            if (averages_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat %p", $time, got);
            end else begin
               want = averages_expected.pop_front();
               if (got.stored !== want.stored) begin
                  errors++;
                  $display("%0t: stored exp %0d got %0d", $time, want.stored, got.stored);
               end
               if (got.oldest_temp !== want.oldest_temp) begin
                  errors++;
                  $display("%0t: oldest_temperature exp %0d got %0d", $time,
                           want.oldest_temp, got.oldest_temp);
               end
               if (got.avg_temp !== want.avg_temp) begin
                  errors++;
                  $display("%0t: avg_temperature exp %0d got %0d", $time,
                           want.avg_temp, got.avg_temp);
               end
               if (got.avg_pres !== want.avg_pres) begin
                  errors++;
                  $display("%0t: avg_pressure exp %0d got %0d", $time,
                           want.avg_pres, got.avg_pres);
               end
               if (got.avg_humi !== want.avg_humi) begin
                  errors++;
                  $display("%0t: avg_humidity exp %0d got %0d", $time,
                           want.avg_humi, got.avg_humi);
               end
               if (got.temp_ok !== want.temp_ok) begin
                  errors++;
                  $display("%0t: temperature_ok exp %0d got %0d", $time,
                           want.temp_ok, got.temp_ok);
               end
               if (got.pres_ok !== want.pres_ok) begin
                  errors++;
                  $display("%0t: pressure_ok exp %0d got %0d", $time,
                           want.pres_ok, got.pres_ok);
               end
               if (got.humi_ok !== want.humi_ok) begin
                  errors++;
                  $display("%0t: humidity_ok exp %0d got %0d", $time,
                           want.humi_ok, got.humi_ok);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_reading(input logic [gwa_pkg::TIME_W-1:0] t, input int tp,
                              input int p, input int h);
      reading_type rd;
      rd.now_ms = t;
      rd.temp   = gwa_pkg::TEMP_W'(tp);
      rd.pres   = gwa_pkg::PRES_W'(p);
      rd.humi   = gwa_pkg::HUMI_W'(h);
      readings_pending.push_back(rd);
   endtask

   task automatic csr_write(input logic [gwa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gwa_pkg::CSR_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      if (idx == gwa_pkg::REG_WINDOW_LENGTH) set_window_len(v);
      else if (idx == gwa_pkg::REG_MIN_INTERVAL) min_gap_ms = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (readings_pending.size() > 0 || averages_expected.size() > 0 || req_bus.valid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic int pick_temp();
      case ($urandom_range(9))
         0: return gwa_pkg::TEMP_LIMIT;
         1: return gwa_pkg::TEMP_LIMIT + 1;
         2: return -8000;
         3: return 8500;
         default: return int'($urandom_range(16500)) - 8000;
      endcase
   endfunction

   function automatic int pick_level(input int top);
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return top;
         default: return $urandom_range(top);
      endcase
   endfunction

   logic [gwa_pkg::TIME_W-1:0] clock_ms;
   int unsigned step;
   int window_set[5] = '{16, 1, 5, 0, 31};
   int gap_set[5]    = '{200, 0, 65535, 100, 37};

   initial begin
      req_bus.valid = 1'b0;
      req_bus.now_ms = '0;
      req_bus.sample_temperature = '0;
      req_bus.sample_pressure = '0;
      req_bus.sample_humidity = '0;
      rsp_bus.ready = 1'b0;
      window_len = gwa_pkg::WL_RESET;
      min_gap_ms = gwa_pkg::MIN_RESET;
      last_store_ms = '0;
      clear_window();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // boundary readings under the reset settings
      add_reading(32'd200, 100, 1000, 1000);
      add_reading(32'd201, 8500, 131071, 102400);
      add_reading(32'd300, 0, 5, 5);
      add_reading(32'd402, -8000, 0, 0);
      add_reading(32'd603, gwa_pkg::TEMP_LIMIT, 0, 0);
      add_reading(32'd804, gwa_pkg::TEMP_LIMIT + 1, 1, 1);
      add_reading(32'd1005, 0, 65536, 65536);
      add_reading(32'hFFFF_FF00, -1, 99999, 51200);
      add_reading(32'd5, 1234, 2, 3);
      add_reading(32'd5, 4321, 4, 6);
      add_reading(32'hAAAA_AAAA, -4000, 43690, 21845);
      add_reading(32'h5555_5555, 4000, 87381, 87381);
      drain();

      clock_ms = 32'h5555_5555;
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = ph < 2 ? 33 : (ph < 4 ? 51 : 0);
         recv_idle_pct = ph < 2 ? 51 : (ph < 4 ? 33 : 0);
         if (ph > 0) begin
            csr_write(gwa_pkg::REG_WINDOW_LENGTH, gwa_pkg::CSR_W'(window_set[ph]));
            csr_write(gwa_pkg::REG_MIN_INTERVAL, gwa_pkg::CSR_W'(gap_set[ph]));
         end
         for (int i = 0; i < 220; i++) begin
            case ($urandom_range(9))
               0, 1, 2: step = $urandom_range(min_gap_ms);
               9: step = $urandom;
               default: step = min_gap_ms + 1 + $urandom_range(300);
            endcase
            clock_ms += step;
            add_reading(clock_ms, pick_temp(), pick_level(131071), pick_level(102400));
         end
         drain();
      end

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
